>>> design/indexed_bitmap_pixel_unpacker_macros.svh
// Assertion helpers for the unpacker RTL.
`ifndef INDEXED_BITMAP_PIXEL_UNPACKER_MACROS_SVH
`define INDEXED_BITMAP_PIXEL_UNPACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IBPU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IBPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ibpu_pkg.sv
package ibpu_pkg;

  // Input transaction kinds
  typedef enum logic {
    ACT_RASTER  = 1'b0,
    ACT_PALETTE = 1'b1
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam int CFG_DW = 13;

  // Pixels per raster byte in each mode
  localparam logic [3:0] PIX_PER_BYTE_1BPP = 4'd8;
  localparam logic [3:0] PIX_PER_BYTE_4BPP = 4'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              pixel_mode;
    logic [CFG_DW-1:0] image_width;
    logic [CFG_DW-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    rgb_t       rgb;
  } pal_wr_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic        last_of_byte;
    logic        frame_end;
  } pix_meta_t;

endpackage

>>> design/ibpu_palette.sv
module ibpu_palette
  import ibpu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pal_wr_t    wr,
  input  logic       ren,
  input  logic [3:0] raddr,
  output rgb_t       rdata
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  rgb_t                     mem_r [PALETTE_DEPTH];
  rgb_t                     rdata_r;
  logic                     rhit_r;
  logic [PALETTE_DEPTH-1:0] valid_r;
  logic                     wr_ok;
  logic                     rd_ok;

  // Drop accesses beyond the palette depth
  assign wr_ok = wr.en && (32'(wr.addr) < PALETTE_DEPTH);
  assign rd_ok = 32'(raddr) < PALETTE_DEPTH;

  // Storage and registered read port; a same-cycle write is seen next cycle
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr.addr[AW-1:0]] <= wr.rgb;
    end
    if (ren) begin
      rdata_r <= mem_r[raddr[AW-1:0]];
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rhit_r  <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_r[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (ren) begin
        rhit_r <= rd_ok && valid_r[raddr[AW-1:0]];
      end
    end
  end

  assign rdata = rhit_r ? rdata_r : '0;

endmodule

>>> design/ibpu_expander.sv
module ibpu_expander
  import ibpu_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       restart,
  input  logic       byte_load,
  input  logic [7:0] byte_data,
  input  logic       adv,
  output logic       ready,
  output logic       pix_valid,
  output logic [3:0] pix_index,
  output pix_meta_t  pix_meta
);

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BIR_W = $clog2(((MAX_WIDTH + 1) / 2 + 3) / 4 * 4);
  localparam int XW    = BIR_W + 3;

  logic [W_W-1:0]   eff_w;
  logic [H_W-1:0]   eff_h;
  logic [ROW_W-1:0] h_m1;
  logic [XW-1:0]    w_x;
  logic [XW-1:0]    w_m1;
  logic [XW-1:0]    data_bytes;
  logic [BIR_W-1:0] row_last;
  logic [3:0]       per_byte;
  logic [XW-1:0]    x0;
  logic [XW-1:0]    remain;
  logic             pad;
  logic [3:0]       n_pix;
  logic             last;

  logic             busy_r, busy_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [XW-1:0]    x_r, x_nxt;
  logic [ROW_W-1:0] prow_r, prow_nxt;
  logic [BIR_W-1:0] bir_r, bir_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Saturate frame geometry
  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = W_W'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = H_W'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      eff_h = H_W'(MAX_HEIGHT);
    end else begin
      eff_h = H_W'(cfg.image_height);
    end
  end

  assign h_m1 = ROW_W'(eff_h - H_W'(1));
  assign w_x  = XW'(eff_w);
  assign w_m1 = w_x - XW'(1);

  // Row length in bytes, padded to a multiple of four
  assign per_byte   = cfg.pixel_mode ? PIX_PER_BYTE_4BPP : PIX_PER_BYTE_1BPP;
  assign data_bytes = cfg.pixel_mode ? ((w_x + XW'(1)) >> 1) : ((w_x + XW'(7)) >> 3);
  assign row_last   = BIR_W'((data_bytes - XW'(1)) | XW'(3));

  // First column of the incoming byte and how many pixels it carries
  assign x0     = cfg.pixel_mode ? XW'({bir_r, 1'b0}) : XW'({bir_r, 3'b000});
  assign pad    = x0 >= w_x;
  assign remain = w_x - x0;
  assign n_pix  = (remain >= XW'(per_byte)) ? per_byte : remain[3:0];

  assign last  = cnt_r == 4'd1;
  assign ready = !busy_r || (adv && last);

  // Expansion and frame position
  always_comb begin
    busy_nxt = busy_r;
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    prow_nxt = prow_r;
    bir_nxt  = bir_r;
    row_nxt  = row_r;
    if (adv) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        data_nxt = cfg.pixel_mode ? {data_r[3:0], 4'b0000} : {data_r[6:0], 1'b0};
        cnt_nxt  = cnt_r - 4'd1;
        x_nxt    = x_r + XW'(1);
      end
    end
    if (byte_load) begin
      if (!pad) begin
        busy_nxt = 1'b1;
        data_nxt = byte_data;
        cnt_nxt  = n_pix;
        x_nxt    = x0;
        prow_nxt = row_r;
      end
      if (bir_r >= row_last) begin
        bir_nxt = '0;
        row_nxt = (row_r == '0) ? h_m1 : row_r - ROW_W'(1);
      end else begin
        bir_nxt = bir_r + BIR_W'(1);
      end
    end
    if (restart) begin
      bir_nxt = '0;
      row_nxt = h_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      bir_r  <= '0;
      row_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      bir_r  <= bir_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    x_r    <= x_nxt;
    prow_r <= prow_nxt;
  end

  // Current pixel: index from the top of the shifted byte
  assign pix_valid             = busy_r;
  assign pix_index             = cfg.pixel_mode ? data_r[7:4] : {3'b000, data_r[7]};
  assign pix_meta.x            = 12'(x_r);
  assign pix_meta.y            = 12'(prow_r);
  assign pix_meta.last_of_byte = last;
  assign pix_meta.frame_end    = (prow_r == '0) && (x_r == w_m1);

endmodule

>>> design/indexed_bitmap_pixel_unpacker.sv
// Palette-indexed bitmap raster unpacker, 1-bit and 4-bit pixel modes.
// Input channel (in_valid/in_ready): in_action selects a palette entry write
// (in_palette_index, in_entry_*) or a raster byte (in_data_byte). Raster
// bytes arrive bottom row first, each row padded to a multiple of 4 bytes.
// Output channel (out_valid/out_ready): one transaction per pixel with its
// color, column, row, last_of_byte and frame_end flags.
// Config port: cfg_we with cfg_index 0 = pixel_mode, 1 = image_width,
// 2 = image_height; any of these writes restarts the frame. Write only idle.
// Occupancy: a raster byte occupies the expander until its pixels, up to 8
// in 1-bit mode and up to 2 in 4-bit mode, have all moved to the output
// register, with one palette read per emitted pixel; padding bytes and
// palette writes never occupy the expander. A new transaction is taken in
// the cycle the previous byte's last pixel moves to the output register.
// Pixel path: an accepted byte is held in the expander registers, and each
// pixel moves to the output register along with its palette memory read.
// Reset: palette reads as zero until written, mode 1-bit, 1x1 frame.
// Receiver stall: the output register holds; the expander stops on the
// current pixel and in_ready drops until that byte is finished.
module indexed_bitmap_pixel_unpacker
  import ibpu_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [7:0]        in_data_byte,
  input  logic [3:0]        in_palette_index,
  input  logic [7:0]        in_entry_red,
  input  logic [7:0]        in_entry_green,
  input  logic [7:0]        in_entry_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel_red,
  output logic [7:0]        out_pixel_green,
  output logic [7:0]        out_pixel_blue,
  output logic [11:0]       out_pixel_x,
  output logic [11:0]       out_pixel_y,
  output logic              out_last_of_byte,
  output logic              out_frame_end
);

  `include "indexed_bitmap_pixel_unpacker_macros.svh"

  cfg_t      cfg_r, cfg_nxt;
  logic      restart;
  logic      accept;
  logic      byte_load;
  pal_wr_t   pal_wr;
  logic      exp_ready;
  logic      exp_valid;
  logic [3:0] exp_index;
  pix_meta_t exp_meta;
  logic      adv;
  logic      out_valid_r, out_valid_nxt;
  pix_meta_t meta_r;
  rgb_t      pal_rgb;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_MODE: begin
          cfg_nxt.pixel_mode = cfg_data[0];
          restart            = 1'b1;
        end
        REG_IMAGE_WIDTH: begin
          cfg_nxt.image_width = cfg_data;
          restart             = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          cfg_nxt.image_height = cfg_data;
          restart              = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode   <= 1'b0;
      cfg_r.image_width  <= CFG_DW'(1);
      cfg_r.image_height <= CFG_DW'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input transaction split into palette write or raster byte
  assign in_ready  = exp_ready;
  assign accept    = in_valid && in_ready;
  assign byte_load = accept && (in_action == ACT_RASTER);

  assign pal_wr.en        = accept && (in_action == ACT_PALETTE);
  assign pal_wr.addr      = in_palette_index;
  assign pal_wr.rgb.red   = in_entry_red;
  assign pal_wr.rgb.green = in_entry_green;
  assign pal_wr.rgb.blue  = in_entry_blue;

  // Advance a pixel into the output register when it is free or draining
  assign adv = exp_valid && (!out_valid_r || out_ready);

  // Expander sees the incoming register value so a restart uses the new height
  ibpu_expander #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_expander (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_nxt),
    .restart   (restart),
    .byte_load (byte_load),
    .byte_data (in_data_byte),
    .adv       (adv),
    .ready     (exp_ready),
    .pix_valid (exp_valid),
    .pix_index (exp_index),
    .pix_meta  (exp_meta)
  );

  ibpu_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (pal_wr),
    .ren   (adv),
    .raddr (exp_index),
    .rdata (pal_rgb)
  );

  // Output register: color comes straight from the palette read register
  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r <= exp_meta;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_red    = pal_rgb.red;
  assign out_pixel_green  = pal_rgb.green;
  assign out_pixel_blue   = pal_rgb.blue;
  assign out_pixel_x      = meta_r.x;
  assign out_pixel_y      = meta_r.y;
  assign out_last_of_byte = meta_r.last_of_byte;
  assign out_frame_end    = meta_r.frame_end;

  // Checks
  `IBPU_ASSERT_SAME(a_frame_end_last, out_valid && out_frame_end, out_last_of_byte, "frame end not on last pixel of byte")
  `IBPU_ASSERT_SAME(a_accept_idle, accept, !exp_valid || (adv && exp_meta.last_of_byte), "transaction taken while byte still expanding")
  `IBPU_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_ready, !adv, "output register overwritten under stall")
  `IBPU_ASSERT_NEXT(a_adv_fills, adv, out_valid, "advanced pixel missing from output")

endmodule

>>> dv/indexed_bitmap_pixel_unpacker_tb.sv
module indexed_bitmap_pixel_unpacker_tb;
  import ibpu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int MAX_W        = 4096;
  localparam int MAX_H        = 4096;
  localparam int PAL_DEPTH    = 16;
  localparam int ITEM_TARGET  = 420;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 1000000;

  // One input transaction: a raster byte or a palette entry write
  typedef struct {
    action_t    act;
    logic [7:0] data;
    logic [3:0] pidx;
    rgb_t       color;
  } bmp_txn_t;

  // One decoded pixel
  typedef struct {
    rgb_t      color;
    pix_meta_t meta;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = ACT_RASTER;
  logic [7:0]        in_data_byte = '0;
  logic [3:0]        in_palette_index = '0;
  logic [7:0]        in_entry_red = '0;
  logic [7:0]        in_entry_green = '0;
  logic [7:0]        in_entry_blue = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_pixel_red;
  logic [7:0]        out_pixel_green;
  logic [7:0]        out_pixel_blue;
  logic [11:0]       out_pixel_x;
  logic [11:0]       out_pixel_y;
  logic              out_last_of_byte;
  logic              out_frame_end;

  // Decoder state mirrored by the predictor
  rgb_t              palette_model [PAL_DEPTH];
  logic              cfg_mode = 1'b0;
  logic [CFG_DW-1:0] cfg_width = 13'd1;
  logic [CFG_DW-1:0] cfg_height = 13'd1;
  int                byte_pos = 0;
  int                cur_row = 0;

  bmp_txn_t pending_txns [$];
  pixel_t   expected_pixels [$];
  bmp_txn_t drv_txn;
  pixel_t   mon_px;

  bit in_taken = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int tx_gap = 0;
  int rx_stall = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int items_queued = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int pixels_checked = 0;
  int frames_seen = 0;
  int raster_bytes_sent = 0;
  int palette_writes_sent = 0;
  int settings_used = 0;

  indexed_bitmap_pixel_unpacker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_palette_index (in_palette_index),
    .in_entry_red     (in_entry_red),
    .in_entry_green   (in_entry_green),
    .in_entry_blue    (in_entry_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_red    (out_pixel_red),
    .out_pixel_green  (out_pixel_green),
    .out_pixel_blue   (out_pixel_blue),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_of_byte (out_last_of_byte),
    .out_frame_end    (out_frame_end)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Clamp a size register to its legal range
  function automatic int eff_size(logic [CFG_DW-1:0] val, int max_val);
    if (val < 1) return 1;
    if (val > max_val) return max_val;
    return val;
  endfunction

  function automatic void restart_frame();
    byte_pos = 0;
    cur_row = eff_size(cfg_height, MAX_H) - 1;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_PIXEL_MODE:   cfg_mode = val[0];
      REG_IMAGE_WIDTH:  cfg_width = val;
      REG_IMAGE_HEIGHT: cfg_height = val;
      default: return;
    endcase
    restart_frame();
  endfunction

  // Expand one raster byte into its pixels and advance the raster position
  function automatic void expand_raster(logic [7:0] data);
    int         w;
    int         per;
    int         row_bytes;
    int         x0;
    int         x;
    int         h;
    logic [3:0] idx;
    pixel_t     px;
    w = eff_size(cfg_width, MAX_W);
    h = eff_size(cfg_height, MAX_H);
    per = cfg_mode ? 2 : 8;
    row_bytes = ((w + per - 1) / per + 3) / 4 * 4;
    x0 = byte_pos * per;
    for (int k = 0; k < per && x0 + k < w; k++) begin
      x = x0 + k;
      if (cfg_mode)
        idx = (k == 0) ? data[7:4] : data[3:0];
      else
        idx = {3'b000, data[7 - k]};
      px.color = palette_model[idx];
      px.meta.x = x[11:0];
      px.meta.y = cur_row[11:0];
      px.meta.last_of_byte = (k + 1 == per) || (x + 1 == w);
      px.meta.frame_end = (cur_row == 0) && (x + 1 == w);
      expected_pixels.push_back(px);
    end
    byte_pos++;
    if (byte_pos >= row_bytes) begin
      byte_pos = 0;
      if (cur_row == 0 || cur_row >= h)
        cur_row = h - 1;
      else
        cur_row--;
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void queue_raster(logic [7:0] data);
    bmp_txn_t t;
    t.act = ACT_RASTER;
    t.data = data;
    t.pidx = 4'($urandom_range(0, 15));
    t.color = 24'($urandom);
    pending_txns.push_back(t);
    items_queued++;
  endfunction

  function automatic void queue_palette(logic [3:0] idx, rgb_t color);
    bmp_txn_t t;
    t.act = ACT_PALETTE;
    t.data = 8'($urandom);
    t.pidx = idx;
    t.color = color;
    pending_txns.push_back(t);
    items_queued++;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, value[CFG_DW-1:0]);
  endtask

  task automatic set_frame(input bit mode, input int w, input int h);
    write_reg(REG_PIXEL_MODE, mode);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    settings_used++;
  endtask

  // Hold until every transaction is sent and every pixel has come out
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_txns.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Driver: present the next pending transaction after a random gap
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_txns.size() > 0) begin
        drv_txn = pending_txns.pop_front();
        in_action <= drv_txn.act;
        in_data_byte <= drv_txn.data;
        in_palette_index <= drv_txn.pidx;
        in_entry_red <= drv_txn.color.red;
        in_entry_green <= drv_txn.color.green;
        in_entry_blue <= drv_txn.color.blue;
        in_valid <= 1'b1;
        tx_gap = tx_burst ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done++;
      rx_stall = LONG_HOLD;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else if (!rx_burst && $urandom_range(0, 99) < 30) begin
      rx_stall = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check each pixel transaction, then predict from the accepted input
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel at x=%0d y=%0d", out_pixel_x, out_pixel_y);
        fail_count++;
      end else begin
        mon_px = expected_pixels.pop_front();
        check_field("pixel_red", mon_px.color.red, out_pixel_red);
        check_field("pixel_green", mon_px.color.green, out_pixel_green);
        check_field("pixel_blue", mon_px.color.blue, out_pixel_blue);
        check_field("pixel_x", mon_px.meta.x, out_pixel_x);
        check_field("pixel_y", mon_px.meta.y, out_pixel_y);
        check_field("last_of_byte", mon_px.meta.last_of_byte, out_last_of_byte);
        check_field("frame_end", mon_px.meta.frame_end, out_frame_end);
        pixels_checked++;
        if (mon_px.meta.frame_end) frames_seen++;
      end
    end
    if (in_taken) begin
      if (in_action == ACT_PALETTE) begin
        palette_model[in_palette_index] = {in_entry_red, in_entry_green, in_entry_blue};
        palette_writes_sent++;
      end else begin
        expand_raster(in_data_byte);
        raster_bytes_sent++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int w;
    int h;
    int n;
    int r;
    int phase;
    bit mode;
    foreach (palette_model[i]) palette_model[i] = '0;
    restart_frame();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: 1x1 frame, 1-bit pixels, palette still zero.
    // One data byte, three padding bytes, a wrapped frame, then palette writes.
    queue_raster(8'h80);
    queue_raster(8'h00);
    queue_raster(8'h00);
    queue_raster(8'h00);
    queue_raster(8'hFF);
    queue_palette(4'd0, 24'hFF00FF);
    queue_palette(4'd1, 24'h00FF00);
    queue_palette(4'd15, 24'hFFFFFF);
    wait_idle();

    // 4-bit, 3x2: partial last byte, padding, frame end and wrap
    set_frame(1'b1, 3, 2);
    queue_raster(8'hF0);
    queue_raster(8'h1F);
    queue_raster(8'h00);
    queue_raster(8'h00);
    queue_raster(8'h0F);
    queue_raster(8'h10);
    queue_raster(8'hAA);
    queue_raster(8'h55);
    queue_raster(8'h01);
    wait_idle();

    // Zero sizes clamp to a 1x1 frame
    set_frame(1'b0, 0, 0);
    queue_raster(8'h7F);
    wait_idle();

    // Oversized width and the largest height
    set_frame(1'b1, 8191, MAX_H);
    queue_raster(8'hF1);
    queue_raster(8'h0E);
    wait_idle();

    // Largest width and oversized height
    set_frame(1'b0, MAX_W, 8191);
    queue_raster(8'hA5);
    wait_idle();

    // Random frames: well-formed raster streams with palette updates mixed in
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 80) w = $urandom_range(1, 24);
      else w = $urandom_range(25, 64);
      h = $urandom_range(0, 4);
      set_frame(mode, w, h);
      n = $urandom_range(20, 50);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 15)
          queue_palette(4'($urandom_range(0, 15)), 24'($urandom));
        else
          queue_raster(8'($urandom));
        // Occasionally pause the sender mid-frame until the output drains
        if (i == n / 2 && $urandom_range(0, 4) == 0) wait_idle();
      end
      // Hold the output long enough to back up the input
      if (phase == 2) begin
        tx_burst = 1'b1;
        holds_asked++;
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_pixels.size());
      fail_count++;
    end
    $display("Decoded %0d raster bytes and %0d palette writes across %0d frame settings",
             raster_bytes_sent, palette_writes_sent, settings_used);
    $display("Compared %0d pixels, %0d of them frame ends", pixels_checked, frames_seen);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> indexed_bitmap_pixel_unpacker.f
+incdir+design
design/ibpu_pkg.sv
design/ibpu_palette.sv
design/ibpu_expander.sv
design/indexed_bitmap_pixel_unpacker.sv
dv/indexed_bitmap_pixel_unpacker_tb.sv
